// ===== rtl/core/utt_pkg.sv =====
// ----------------------------------------------------------------------------
// utt_pkg
// Shared types, constants and the UTF-8 byte selection function used by the
// front classifier and the back serializer of the UTF-16 to UTF-8 transcoder.
// ----------------------------------------------------------------------------
package utt_pkg;

	// default depth of the queue between front and back
	localparam int UTT_QUEUE_DEPTH = 2;

	// code point width: 20 bits of surrogate payload plus 0x10000
	localparam int UTT_CP_W = 21;

	// configuration register indexes
	localparam logic UTT_REG_BIG_ENDIAN   = 1'b0;
	localparam logic UTT_REG_STOP_AT_NULL = 1'b1;

	// index of the last byte of an encoded code point (byte count minus one)
	localparam logic [1:0] UTT_LEN1 = 2'd0;
	localparam logic [1:0] UTT_LEN2 = 2'd1;
	localparam logic [1:0] UTT_LEN3 = 2'd2;
	localparam logic [1:0] UTT_LEN4 = 2'd3;

	// one classified item waiting for the serializer
	typedef struct packed {
		logic [UTT_CP_W-1:0] cp;
		logic [1:0]          last_idx;
		logic                eos;
	} utt_entry_t;

	// byte number idx of the UTF-8 form of cp, whose length is given by last_idx
	function automatic logic [7:0] utt_byte(input logic [UTT_CP_W-1:0] cp,
		input logic [1:0] last_idx, input logic [1:0] idx);
		logic [7:0] b;
		b = {2'b10, cp[5:0]};
		case (last_idx)
			UTT_LEN1: b = {1'b0, cp[6:0]};
			UTT_LEN2: begin
				if (idx == 2'd0) b = {3'b110, cp[10:6]};
				else b = {2'b10, cp[5:0]};
			end
			UTT_LEN3: begin
				case (idx)
					2'd0:    b = {4'b1110, cp[15:12]};
					2'd1:    b = {2'b10, cp[11:6]};
					default: b = {2'b10, cp[5:0]};
				endcase
			end
			UTT_LEN4: begin
				case (idx)
					2'd0:    b = {5'b11110, cp[20:18]};
					2'd1:    b = {2'b10, cp[17:12]};
					2'd2:    b = {2'b10, cp[11:6]};
					default: b = {2'b10, cp[5:0]};
				endcase
			end
			default: b = {2'b10, cp[5:0]};
		endcase
		return b;
	endfunction

endpackage

// ===== rtl/core/utt_front.sv =====
// ----------------------------------------------------------------------------
// utt_front
// Accepts code units, applies byte order, pairs surrogates and classifies
// each code point by UTF-8 length before pushing it into the queue.
// ----------------------------------------------------------------------------
module utt_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic                cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          first_byte,
	input  logic [7:0]          second_byte,
	input  logic                q_full,
	output logic                push,
	output utt_pkg::utt_entry_t push_entry
);
	import utt_pkg::*;

	logic                big_endian_q;
	logic                stop_at_null_q;
	logic                pending_q;
	logic [9:0]          held_q;
	logic [15:0]         unit;
	logic                is_high;
	logic                accept;
	logic [UTT_CP_W-1:0] cp;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			big_endian_q   <= 1'b0;
			stop_at_null_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				UTT_REG_BIG_ENDIAN:   big_endian_q   <= cfg_data;
				UTT_REG_STOP_AT_NULL: stop_at_null_q <= cfg_data;
				default:              ;
			endcase
		end
	end

	// unit assembly and surrogate detection
	assign unit     = big_endian_q ? {first_byte, second_byte} : {second_byte, first_byte};
	assign is_high  = (unit[15:10] == 6'b110110);
	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// code point: paired surrogate or plain unit
	always_comb begin
		if (pending_q) cp = {1'b0, held_q, unit[9:0]} + 21'h10000;
		else cp = {5'd0, unit};
	end

	// classification by encoded length
	always_comb begin
		push_entry.cp  = cp;
		push_entry.eos = !pending_q && (unit == 16'd0) && stop_at_null_q;
		if (cp < 21'h80) push_entry.last_idx = UTT_LEN1;
		else if (cp < 21'h800) push_entry.last_idx = UTT_LEN2;
		else if (cp < 21'h10000) push_entry.last_idx = UTT_LEN3;
		else push_entry.last_idx = UTT_LEN4;
	end

	// a lone high surrogate is only held
	assign push = accept && (pending_q || !is_high);

	// surrogate hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 1'b0;
			held_q    <= 10'd0;
		end else if (accept) begin
			if (pending_q) begin
				pending_q <= 1'b0;
				held_q    <= 10'd0;
			end else if (is_high) begin
				pending_q <= 1'b1;
				held_q    <= unit[9:0];
			end
		end
	end

endmodule

// ===== rtl/core/utt_queue.sv =====
// ----------------------------------------------------------------------------
// utt_queue
// Short first-in first-out queue of classified items between the front
// classifier and the back serializer.
// ----------------------------------------------------------------------------
module utt_queue #(
	parameter int DEPTH = utt_pkg::UTT_QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  utt_pkg::utt_entry_t push_entry,
	output logic                full,
	input  logic                pop,
	output logic                head_valid,
	output utt_pkg::utt_entry_t head_entry
);
	import utt_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	utt_entry_t    mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_entry = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_entry;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			if (pop) rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			if (push && !pop) count_q <= count_q + CW'(1);
			else if (pop && !push) count_q <= count_q - CW'(1);
		end
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count above depth");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("queue popped while empty");
	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + CW'(1))
		else $error("queue count did not follow push");
`endif

endmodule

// ===== rtl/core/utt_back.sv =====
// ----------------------------------------------------------------------------
// utt_back
// Serializer: takes classified items from the queue and sends their UTF-8
// bytes one per cycle through a registered output stage when out is ready.
// ----------------------------------------------------------------------------
module utt_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  utt_pkg::utt_entry_t head_entry,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [7:0]          utf8_byte,
	output logic                last_of_run,
	output logic                end_of_string
);
	import utt_pkg::*;

	utt_entry_t cur_q;
	logic       cur_valid_q;
	logic [1:0] idx_q;
	logic       out_valid_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic       eos_q;
	logic       advance;
	logic       last_now;

	// one byte moves into the output register when it is free or drained
	assign advance  = cur_valid_q && (!out_valid_q || out_ready);
	assign last_now = (idx_q == cur_q.last_idx);
	assign pop      = head_valid && (!cur_valid_q || (advance && last_now));

	// current item and byte index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= 2'd0;
		end else if (pop) begin
			cur_valid_q <= 1'b1;
			idx_q       <= 2'd0;
		end else if (advance) begin
			idx_q <= idx_q + 2'd1;
			if (last_now) cur_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) cur_q <= head_entry;
	end

	// output stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			byte_q <= utt_byte(cur_q.cp, cur_q.last_idx, idx_q);
			last_q <= last_now;
			eos_q  <= cur_q.eos;
		end
	end

	assign out_valid     = out_valid_q;
	assign utf8_byte     = byte_q;
	assign last_of_run   = last_q;
	assign end_of_string = eos_q;

`ifndef NO_ASSERTIONS
	a_eos_single: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && eos_q) |-> (last_q && byte_q == 8'd0))
		else $error("end marker not a single zero item");
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cur_valid_q |-> (idx_q <= cur_q.last_idx))
		else $error("byte index past item length");
	a_no_loss: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !advance)
		else $error("output overwritten while stalled");
`endif

endmodule

// ===== rtl/core/utf16_to_utf8_transcoder.sv =====
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder
// UTF-16 code units in, UTF-8 bytes out, with surrogate pairing and an
// optional end-of-string marker on a zero unit.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+-------------------------------------
//   in       | in_valid / in_ready   | first_byte, second_byte
//   out      | out_valid / out_ready | utf8_byte, last_of_run, end_of_string
//   cfg      | cfg_we                | cfg_index, cfg_data
//
// An item sends its UTF-8 bytes (1 to 4) one per cycle while out_ready is
// high, through the single-byte output register; a high surrogate is held
// and gives no byte. An item passes the queue, cur_q and the output register.
// Reset clears configuration, surrogate hold, queue and output stage.
// The queue lets input keep flowing for QUEUE_DEPTH items while out stalls.
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder #(
	parameter int QUEUE_DEPTH = utt_pkg::UTT_QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic       cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] first_byte,
	input  logic [7:0] second_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] utf8_byte,
	output logic       last_of_run,
	output logic       end_of_string
);
	import utt_pkg::*;

	logic       q_full;
	logic       push;
	utt_entry_t push_entry;
	logic       pop;
	logic       head_valid;
	utt_entry_t head_entry;

	// classifier
	utt_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.first_byte  (first_byte),
		.second_byte (second_byte),
		.q_full      (q_full),
		.push        (push),
		.push_entry  (push_entry)
	);

	// decoupling queue
	utt_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_entry (head_entry)
	);

	// serializer
	utt_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head_entry    (head_entry),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.utf8_byte     (utf8_byte),
		.last_of_run   (last_of_run),
		.end_of_string (end_of_string)
	);

endmodule

// ===== verif/tb_utf16_to_utf8_transcoder.sv =====
// ----------------------------------------------------------------------------
// tb_utf16_to_utf8_transcoder
// Self-checking bench for the UTF-16 to UTF-8 transcoder. Code units are sent
// in either byte order. A local encoder keeps its own copy of the surrogate
// hold and the register settings, and queues the UTF-8 bytes each item should
// produce. A checker compares every output byte with the oldest queued entry.
// Both sides stall at random. One test holds the output for a long stretch so
// that the input backs up.
// ----------------------------------------------------------------------------
module tb_utf16_to_utf8_transcoder;
	import utt_pkg::*;

	localparam int IDLE_LIMIT    = 1000;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_CYCLES  = 16;
	localparam int HOLD_CYCLES   = 150;
	localparam int PHASE_ITEMS   = 47;
	localparam int MAX_REPORTS   = 10;

	// one expected output byte with its flags
	typedef struct packed {
		logic [7:0] value;
		logic       last;
		logic       eos;
	} utf8_result_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic       cfg_index;
	logic       cfg_data;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] first_byte;
	logic [7:0] second_byte;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] utf8_byte;
	logic       last_of_run;
	logic       end_of_string;

	// encoder copy of the block state and registers
	logic       enc_big_endian   = 1'b0;
	logic       enc_stop_at_null = 1'b0;
	logic       enc_pending      = 1'b0;
	logic [9:0] enc_high_bits    = 10'd0;

	utf8_result_t expected_utf8[$];
	utf8_result_t want;

	int mismatches  = 0;
	int units_sent  = 0;
	int idle_cycles = 0;
	int tx_gap      = 1;
	bit tx_fast     = 1'b0;
	bit rx_fast     = 1'b0;
	bit rx_hold_req = 1'b0;

	utf16_to_utf8_transcoder i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.first_byte   (first_byte),
		.second_byte  (second_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.utf8_byte    (utf8_byte),
		.last_of_run  (last_of_run),
		.end_of_string(end_of_string)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// append one expected byte at the tail of the queue
	function automatic void add_expected(input logic [7:0] byte_val, input logic lst,
		input logic eos_flag);
		utf8_result_t r;
		r.value = byte_val;
		r.last  = lst;
		r.eos   = eos_flag;
		expected_utf8.insert(expected_utf8.size(), r);
	endfunction

	// queue the utf-8 bytes caused by one accepted code unit
	function automatic void encode_unit(input logic [7:0] b0, input logic [7:0] b1);
		logic [15:0] unit;
		logic [20:0] cp;
		logic [7:0]  seq[4];
		int          n;
		unit = enc_big_endian ? {b0, b1} : {b1, b0};
		if (enc_pending) begin
			cp = {1'b0, enc_high_bits, unit[9:0]} + 21'h10000;
			enc_pending = 1'b0;
			enc_high_bits = 10'd0;
		end else if (unit >= 16'hD800 && unit <= 16'hDBFF) begin
			enc_pending = 1'b1;
			enc_high_bits = unit[9:0];
			return;
		end else begin
			cp = {5'd0, unit};
			if (cp == 21'd0 && enc_stop_at_null) begin
				add_expected(8'h00, 1'b1, 1'b1);
				return;
			end
		end
		if (cp < 21'h80) begin
			seq[0] = cp[7:0];
			n = 1;
		end else if (cp < 21'h800) begin
			seq[0] = 8'hC0 + 8'(cp >> 6);
			seq[1] = 8'h80 + 8'(cp & 21'h3F);
			n = 2;
		end else if (cp < 21'h10000) begin
			seq[0] = 8'hE0 + 8'(cp >> 12);
			seq[1] = 8'h80 + 8'((cp >> 6) & 21'h3F);
			seq[2] = 8'h80 + 8'(cp & 21'h3F);
			n = 3;
		end else begin
			seq[0] = 8'hF0 + 8'((cp >> 18) & 21'h0F);
			seq[1] = 8'h80 + 8'((cp >> 12) & 21'h3F);
			seq[2] = 8'h80 + 8'((cp >> 6) & 21'h3F);
			seq[3] = 8'h80 + 8'(cp & 21'h3F);
			n = 4;
		end
		for (int k = 0; k < n; k++)
			add_expected(seq[k], (k == n - 1), 1'b0);
	endfunction

	// send one code unit in the configured byte order; returns at a falling edge
	task automatic send_unit(input logic [15:0] unit);
		logic [7:0] b0;
		logic [7:0] b1;
		b0 = enc_big_endian ? unit[15:8] : unit[7:0];
		b1 = enc_big_endian ? unit[7:0] : unit[15:8];
		if (tx_gap != 0)
			repeat (tx_gap) @(negedge clk);
		first_byte  <= b0;
		second_byte <= b1;
		in_valid    <= 1'b1;
		do @(posedge clk); while (!in_ready);
		encode_unit(b0, b1);
		units_sent++;
		@(negedge clk);
		tx_gap = tx_fast ? 0 : $urandom_range(0, 12);
		if (tx_gap != 0)
			in_valid <= 1'b0;
	endtask

	// drop valid, wait until every expected byte is out, then let the pipe settle
	task automatic wait_idle;
		if (tx_gap == 0) begin
			in_valid <= 1'b0;
			tx_gap = 1;
		end
		while (expected_utf8.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// write both registers while the block is idle
	task automatic set_config(input logic big_endian, input logic stop_at_null);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_index <= UTT_REG_BIG_ENDIAN;
		cfg_data  <= big_endian;
		@(negedge clk);
		cfg_index <= UTT_REG_STOP_AT_NULL;
		cfg_data  <= stop_at_null;
		@(negedge clk);
		cfg_we <= 1'b0;
		enc_big_endian   = big_endian;
		enc_stop_at_null = stop_at_null;
	endtask

	// mostly well-formed text, some zeros, lone and broken surrogates, noise
	task automatic send_random_code;
		int kind;
		kind = $urandom_range(0, 99);
		if (kind < 30)
			send_unit(16'($urandom_range(0, 16'h7F)));
		else if (kind < 45)
			send_unit(16'($urandom_range(16'h80, 16'h7FF)));
		else if (kind < 55)
			send_unit(16'($urandom_range(16'h800, 16'hD7FF)));
		else if (kind < 60)
			send_unit(16'($urandom_range(16'hE000, 16'hFFFF)));
		else if (kind < 80) begin
			send_unit(16'hD800 | 16'($urandom_range(0, 1023)));
			send_unit(16'hDC00 | 16'($urandom_range(0, 1023)));
		end else if (kind < 84)
			send_unit(16'h0000);
		else if (kind < 88)
			send_unit(16'($urandom_range(16'hDC00, 16'hDFFF)));
		else if (kind < 93) begin
			send_unit(16'hD800 | 16'($urandom_range(0, 1023)));
			send_unit(16'($urandom));
		end else
			send_unit(16'($urandom));
	endtask

	// code point boundaries and surrogate cases, reset register values
	task automatic test_code_point_edges;
		logic [15:0] units[] = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF, 16'h0800,
			16'hE000, 16'hFFFF, 16'hDC00, 16'hD800, 16'hDC00, 16'hDBFF, 16'hDFFF,
			16'hD800, 16'h0041, 16'hDBFF, 16'hD800, 16'hD800, 16'h0000};
		foreach (units[i])
			send_unit(units[i]);
	endtask

	// big endian with the end marker on a zero unit
	task automatic test_end_marker;
		logic [15:0] units[] = '{16'h0000, 16'h0041, 16'h0000, 16'hD83D, 16'h0000,
			16'h0000, 16'h00A9, 16'hFFFE};
		set_config(1'b1, 1'b1);
		foreach (units[i])
			send_unit(units[i]);
	endtask

	// a held high surrogate survives an idle pause and a register change
	task automatic test_dangling_surrogate;
		set_config(1'b0, 1'b1);
		send_unit(16'hD83D);
		set_config(1'b1, 1'b0);
		send_unit(16'hDE00);
		send_unit(16'hDBFF);
	endtask

	// random text over all register settings, with and without stalls
	task automatic test_random_text;
		logic [1:0] settings[] = '{2'b00, 2'b11, 2'b01, 2'b10};
		int start;
		foreach (settings[p]) begin
			set_config(settings[p][1], settings[p][0]);
			tx_fast = (p == 0);
			rx_fast = (p == 0);
			start = units_sent;
			while (units_sent - start < PHASE_ITEMS)
				send_random_code();
		end
		tx_fast = 1'b0;
		rx_fast = 1'b0;
	endtask

	// output held off while input streams four-byte pairs, then a full drain
	task automatic test_output_backpressure;
		set_config(1'b0, 1'b0);
		tx_fast = 1'b1;
		rx_hold_req = 1'b1;
		repeat (8) begin
			send_unit(16'hD800 | 16'($urandom_range(0, 1023)));
			send_unit(16'hDC00 | 16'($urandom_range(0, 1023)));
		end
		tx_fast = 1'b0;
		wait_idle();
	endtask

	// receiver: random stall per byte, a long hold on request
	initial begin
		out_ready = 1'b0;
		wait (arst_n);
		@(negedge clk);
		forever begin
			if (rx_hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				rx_hold_req = 1'b0;
			end else if (!rx_fast) begin
				int stall;
				stall = $urandom_range(0, 12);
				if (stall != 0) begin
					out_ready <= 1'b0;
					repeat (stall) @(negedge clk);
				end
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	// compare each accepted byte with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_utf8.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected item: byte %02h last %0d eos %0d",
						utf8_byte, last_of_run, end_of_string);
			end else begin
				want = expected_utf8.pop_front();
				if (utf8_byte !== want.value || last_of_run !== want.last ||
						end_of_string !== want.eos) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("mismatch: expected %02h %0d %0d, got %02h %0d %0d",
							want.value, want.last, want.eos,
							utf8_byte, last_of_run, end_of_string);
				end
			end
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	// test sequence
	initial begin
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = UTT_REG_BIG_ENDIAN;
		cfg_data    = 1'b0;
		in_valid    = 1'b0;
		first_byte  = 8'd0;
		second_byte = 8'd0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_code_point_edges();
		test_end_marker();
		test_random_text();
		test_output_backpressure();
		test_dangling_surrogate();

		wait_idle();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (expected_utf8.size() != 0)
			mismatches++;
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
